[sv/spcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo pulse command parser package
// Shared constants, status codes and the table write type.
// ----------------------------------------------------------------------------
package spcp_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int CHAN_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int INDEX_W   = 3;
    localparam int CHAN_W    = 7;
    localparam int ANGLE_W   = 10;
    localparam int PULSE_W   = 12;
    localparam int PULSE_CALC_W = 15;

    localparam logic [BYTE_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0]  ASCII_NINE  = 8'h39;
    localparam logic [INDEX_W-1:0] CHAN_DIGITS = 3'd2;
    localparam logic [INDEX_W-1:0] LAST_INDEX  = 3'd4;

    localparam logic [PULSE_CALC_W-1:0] PULSE_BASE = 15'd750;
    localparam logic [PULSE_CALC_W-1:0] PULSE_MAX  = 15'd3750;
    localparam logic [PULSE_W-1:0]      PULSE_RESET = 12'd2250;

    // floor(x / 5) for x below 3072 is (x * 6554) >> 15.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_FIFTH = 13'd6554;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        logic                  en;
        logic [CHAN_IDX_W-1:0] index;
        logic [PULSE_W-1:0]    value;
    } t_table_wr;

endpackage

[sv/servo_pulse_command_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo pulse command parser
// Decodes five-digit ASCII servo commands and updates the pulse table.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one received byte per word (i_valid, o_stall,
// i_rx_byte). Two digits give the channel, three digits the angle. A word
// that is not an ASCII digit ends the command with a bad-character result.
// The fifth digit yields a result with the decoded channel and, if the
// channel is 1 to 12 and the pulse fits, the new pulse width, which is also
// written to the table; otherwise an out-of-range result is given.
// The result channel (o_valid, i_stall, o_status, o_channel, o_pulse_width)
// carries one word for each completed or aborted command.
// An accepted byte is held in the input register, and the result word that it
// yields, if any, in the result register. One byte is taken every
// cycle while results drain. When the receiver stalls, the result register
// holds, one more byte waits in the input register, and then o_stall rises.
// Synchronous reset empties both registers, restarts the command and sets
// every table entry to 2250 ticks.
// ----------------------------------------------------------------------------
module servo_pulse_command_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [spcp_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [spcp_pkg::CHAN_W-1:0]   o_channel,
    output logic [spcp_pkg::PULSE_W-1:0]  o_pulse_width
);

    localparam int CHAN_MAC_W  = spcp_pkg::CHAN_W + 4;
    localparam int ANGLE_MAC_W = spcp_pkg::ANGLE_W + 4;

    logic                            r_in_valid;
    logic [spcp_pkg::BYTE_W-1:0]     r_in_byte;
    logic [spcp_pkg::INDEX_W-1:0]    r_digit_index, n_digit_index;
    logic [spcp_pkg::CHAN_W-1:0]     r_channel_acc, n_channel_acc;
    logic [spcp_pkg::ANGLE_W-1:0]    r_angle_acc, n_angle_acc;
    logic                            r_out_valid, n_out_valid;
    spcp_pkg::t_status               r_status, n_status;
    logic [spcp_pkg::CHAN_W-1:0]     r_channel, n_channel;
    logic [spcp_pkg::PULSE_W-1:0]    r_pulse, n_pulse;

    logic                            out_free;
    logic                            fire;
    logic                            accept;
    logic                            is_digit;
    logic [spcp_pkg::DIGIT_W-1:0]    digit;
    logic [CHAN_MAC_W-1:0]           chan_mac;
    logic [ANGLE_MAC_W-1:0]          angle_mac;
    logic [spcp_pkg::ANGLE_W-1:0]    angle;
    logic [spcp_pkg::PULSE_CALC_W-1:0] pulse;
    logic                            in_range;
    spcp_pkg::t_table_wr             table_wr;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    assign is_digit  = (r_in_byte >= spcp_pkg::ASCII_ZERO) && (r_in_byte <= spcp_pkg::ASCII_NINE);
    assign digit     = spcp_pkg::DIGIT_W'(r_in_byte - spcp_pkg::ASCII_ZERO);
    assign chan_mac  = CHAN_MAC_W'(r_channel_acc) * CHAN_MAC_W'(10) + CHAN_MAC_W'(digit);
    assign angle_mac = ANGLE_MAC_W'(r_angle_acc) * ANGLE_MAC_W'(10) + ANGLE_MAC_W'(digit);
    assign angle     = angle_mac[spcp_pkg::ANGLE_W-1:0];

    spcp_pulse_calc u_pulse_calc (
        .i_angle (angle),
        .o_pulse (pulse)
    );

    assign in_range = (pulse <= spcp_pkg::PULSE_MAX) && (r_channel_acc != '0)
                   && (r_channel_acc <= spcp_pkg::CHAN_W'(spcp_pkg::NUM_CHANNELS));

    always_comb begin
        n_digit_index  = r_digit_index;
        n_channel_acc  = r_channel_acc;
        n_angle_acc    = r_angle_acc;
        n_out_valid    = r_out_valid && i_stall;
        n_status       = r_status;
        n_channel      = r_channel;
        n_pulse        = r_pulse;
        table_wr.en    = 1'b0;
        table_wr.index = spcp_pkg::CHAN_IDX_W'(r_channel_acc - spcp_pkg::CHAN_W'(1));
        table_wr.value = pulse[spcp_pkg::PULSE_W-1:0];
        if (fire) begin
            priority if (!is_digit) begin
                n_digit_index = '0;
                n_channel_acc = '0;
                n_angle_acc   = '0;
                n_out_valid   = 1'b1;
                n_status      = spcp_pkg::ST_BAD_CHAR;
                n_channel     = '0;
                n_pulse       = '0;
            end else if (r_digit_index < spcp_pkg::CHAN_DIGITS) begin
                n_channel_acc = chan_mac[spcp_pkg::CHAN_W-1:0];
                n_digit_index = r_digit_index + 1'b1;
            end else if (r_digit_index < spcp_pkg::LAST_INDEX) begin
                n_angle_acc   = angle;
                n_digit_index = r_digit_index + 1'b1;
            end else begin
                n_digit_index = '0;
                n_channel_acc = '0;
                n_angle_acc   = '0;
                n_out_valid   = 1'b1;
                n_channel     = r_channel_acc;
                if (in_range) begin
                    n_status    = spcp_pkg::ST_OK;
                    n_pulse     = pulse[spcp_pkg::PULSE_W-1:0];
                    table_wr.en = 1'b1;
                end else begin
                    n_status = spcp_pkg::ST_RANGE;
                    n_pulse  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_digit_index <= '0;
            r_channel_acc <= '0;
            r_angle_acc   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_in_valid    <= accept || (r_in_valid && !fire);
            r_digit_index <= n_digit_index;
            r_channel_acc <= n_channel_acc;
            r_angle_acc   <= n_angle_acc;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
        r_status  <= n_status;
        r_channel <= n_channel;
        r_pulse   <= n_pulse;
    end

    spcp_pulse_table u_pulse_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (table_wr)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_channel     = r_channel;
    assign o_pulse_width = r_pulse;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("Input stalled without a pending word on both sides.");

    a_bad_char_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !is_digit) |=> (r_digit_index == '0 && o_valid
            && o_status == spcp_pkg::ST_BAD_CHAR && o_channel == '0))
        else $error("Non-digit word did not restart the command.");

    a_reject_zero_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != spcp_pkg::ST_OK) |-> (o_pulse_width == '0))
        else $error("Rejected command carries a nonzero pulse width.");

endmodule

[sv/spcp_pulse_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse calculator
// Converts an angle to timer ticks: floor(angle * 83 / 5) + 750, computed as
// 16 * angle + floor(3 * angle / 5) + 750.
// ----------------------------------------------------------------------------
module spcp_pulse_calc (
    input  logic [spcp_pkg::ANGLE_W-1:0]      i_angle,
    output logic [spcp_pkg::PULSE_CALC_W-1:0] o_pulse
);

    localparam int TRIPLE_W = spcp_pkg::ANGLE_W + 2;
    localparam int PROD_W   = TRIPLE_W + spcp_pkg::RECIP_W;

    logic [TRIPLE_W-1:0]              triple;
    logic [PROD_W-1:0]                prod;
    logic [spcp_pkg::ANGLE_W-1:0]     fifth;
    logic [spcp_pkg::PULSE_CALC_W-1:0] sixteen;

    assign triple  = {1'b0, i_angle, 1'b0} + {2'b00, i_angle};
    assign prod    = PROD_W'(triple) * PROD_W'(spcp_pkg::RECIP_FIFTH);
    assign fifth   = prod[spcp_pkg::RECIP_SHIFT +: spcp_pkg::ANGLE_W];
    assign sixteen = {1'b0, i_angle, 4'b0000};
    assign o_pulse = sixteen + spcp_pkg::PULSE_CALC_W'(fifth) + spcp_pkg::PULSE_BASE;

endmodule

[sv/spcp_pulse_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width table
// One stored pulse width per channel, reset to the center position.
// ----------------------------------------------------------------------------
module spcp_pulse_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spcp_pkg::t_table_wr  i_wr
);

    logic [spcp_pkg::PULSE_W-1:0] r_table [spcp_pkg::NUM_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < spcp_pkg::NUM_CHANNELS; k++) begin
                r_table[k] <= spcp_pkg::PULSE_RESET;
            end
        end else if (i_wr.en) begin
            r_table[i_wr.index] <= i_wr.value;
        end
    end

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> r_table[$past(i_wr.index)] == $past(i_wr.value))
        else $error("Table entry does not hold the value just written.");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo pulse command parser testbench
// Sends directed and random byte streams through the parser with random
// gaps and result stalls. A local model of the command decoder predicts each
// result word, and a checker compares every word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 1820;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        spcp_pkg::t_status                 status;
        logic [spcp_pkg::CHAN_W-1:0]       channel;
        logic [spcp_pkg::PULSE_W-1:0]      pulse;
    } t_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic [spcp_pkg::BYTE_W-1:0]       i_rx_byte = '0;
    logic                              i_stall = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic [1:0]                        o_status;
    logic [spcp_pkg::CHAN_W-1:0]       o_channel;
    logic [spcp_pkg::PULSE_W-1:0]      o_pulse_width;

    // Decoder model state.
    logic [spcp_pkg::INDEX_W-1:0]      cmd_digits;
    logic [spcp_pkg::CHAN_W-1:0]       cmd_channel;
    logic [spcp_pkg::ANGLE_W-1:0]      cmd_angle;
    logic [spcp_pkg::PULSE_W-1:0]      servo_table [spcp_pkg::NUM_CHANNELS];

    t_result pending_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      bytes_sent = 0;
    int      seen_ok = 0;
    int      seen_bad_char = 0;
    int      seen_range = 0;
    bit      quiet = 1'b0;
    int      stall_run = 0;

    servo_pulse_command_parser_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_channel     (o_channel),
        .o_pulse_width (o_pulse_width)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [spcp_pkg::BYTE_W-1:0] random_non_digit();
        logic [spcp_pkg::BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b >= spcp_pkg::ASCII_ZERO && b <= spcp_pkg::ASCII_NINE) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic reset_decoder();
        cmd_digits = '0;
        cmd_channel = '0;
        cmd_angle = '0;
        for (int k = 0; k < spcp_pkg::NUM_CHANNELS; k++) begin
            servo_table[k] = spcp_pkg::PULSE_RESET;
        end
    endtask

    // Returns 1 when the byte completes or aborts a command.
    function automatic bit decode_rx_byte(input logic [spcp_pkg::BYTE_W-1:0] b,
                                          output t_result r);
        int digit;
        int angle;
        int pulse;
        r = '{status: spcp_pkg::ST_OK, channel: '0, pulse: '0};
        if (b < spcp_pkg::ASCII_ZERO || b > spcp_pkg::ASCII_NINE) begin
            cmd_digits = '0;
            cmd_channel = '0;
            cmd_angle = '0;
            r.status = spcp_pkg::ST_BAD_CHAR;
            return 1'b1;
        end
        digit = int'(b - spcp_pkg::ASCII_ZERO);
        if (cmd_digits < spcp_pkg::CHAN_DIGITS) begin
            cmd_channel = spcp_pkg::CHAN_W'(cmd_channel * 10 + digit);
            cmd_digits = cmd_digits + 1'b1;
            return 1'b0;
        end
        if (cmd_digits < spcp_pkg::LAST_INDEX) begin
            cmd_angle = spcp_pkg::ANGLE_W'(cmd_angle * 10 + digit);
            cmd_digits = cmd_digits + 1'b1;
            return 1'b0;
        end
        angle = (int'(cmd_angle) * 10 + digit) & 32'h3FF;
        pulse = angle * 83 / 5 + 750;
        r.channel = cmd_channel;
        if (pulse <= 3750 && cmd_channel >= 1 && cmd_channel <= spcp_pkg::NUM_CHANNELS) begin
            servo_table[cmd_channel - 1] = spcp_pkg::PULSE_W'(pulse);
            r.status = spcp_pkg::ST_OK;
            r.pulse = spcp_pkg::PULSE_W'(pulse);
        end else begin
            r.status = spcp_pkg::ST_RANGE;
        end
        cmd_digits = '0;
        cmd_channel = '0;
        cmd_angle = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Valid stays high across back-to-back words and drops only for a gap.
    task automatic send_byte(input logic [spcp_pkg::BYTE_W-1:0] b);
        int gap;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (decode_rx_byte(b, r)) begin
            pending_results.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic send_command(input int chan, input int angle);
        send_byte(8'(spcp_pkg::ASCII_ZERO + chan / 10));
        send_byte(8'(spcp_pkg::ASCII_ZERO + chan % 10));
        send_byte(8'(spcp_pkg::ASCII_ZERO + angle / 100));
        send_byte(8'(spcp_pkg::ASCII_ZERO + (angle / 10) % 10));
        send_byte(8'(spcp_pkg::ASCII_ZERO + angle % 10));
    endtask

    task automatic send_digits(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(8'(spcp_pkg::ASCII_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic test_extreme_bytes();
        send_byte(8'h00);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(8'hFF);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(spcp_pkg::ASCII_ZERO - 1'b1);
        send_byte(spcp_pkg::ASCII_ZERO + 1'b1);
        send_byte(spcp_pkg::ASCII_ZERO + 2'd3);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(spcp_pkg::ASCII_NINE);
        send_byte(spcp_pkg::ASCII_NINE + 1'b1);
    endtask

    task automatic test_command_ranges();
        send_command(1, 180);
        send_command(spcp_pkg::NUM_CHANNELS, 0);
        send_command(5, 181);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        for (int k = 0; k < 6; k++) begin
            send_command($urandom_range(0, 15), $urandom_range(0, 200));
        end
        send_byte(random_non_digit());
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int kind;
        int chan;
        int angle;
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                chan = ($urandom_range(0, 4) != 0)
                       ? $urandom_range(1, spcp_pkg::NUM_CHANNELS)
                       : $urandom_range(0, 99);
                angle = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 180)
                                                    : $urandom_range(0, 999);
                send_command(chan, angle);
            end else if (kind < 85) begin
                send_digits($urandom_range(0, 4));
                send_byte(random_non_digit());
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            i_stall <= ($urandom_range(0, 2) == 0);
            stall_run <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, status", o_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_channel !== want.channel) begin
                    report_mismatch("channel", o_channel, want.channel);
                end
                if (o_pulse_width !== want.pulse) begin
                    report_mismatch("pulse width", o_pulse_width, want.pulse);
                end
                case (want.status)
                    spcp_pkg::ST_OK:       seen_ok++;
                    spcp_pkg::ST_BAD_CHAR: seen_bad_char++;
                    default:               seen_range++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout with %0d result words outstanding", pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        reset_decoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_bytes();
        test_command_ranges();
        test_back_to_back();
        test_random_traffic();

        i_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes; results checked: %0d accepted, %0d bad character, %0d out of range.",
                 bytes_sent, seen_ok, seen_bad_char, seen_range);
        $display("Mismatches: %0d.", error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
sv/spcp_pkg.sv
sv/spcp_pulse_calc.sv
sv/spcp_pulse_table.sv
sv/servo_pulse_command_parser_core.sv
verif/testbench.sv
